@@ rtl/rws_pkg.sv @@
// Shared types, command codes, register indexes and constants of the report wake scheduler.
package rws_pkg;

    // Field widths
    localparam int CMD_W     = 2;
    localparam int TIME_W    = 64;
    localparam int MS_W      = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    // Retry table
    localparam int RETRY_LEVELS = 4;
    localparam int LVL_W        = 2;

    // Commands
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SUCCESS = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FAIL    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_METER_IV   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BATT_IV    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_0    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_LAST = 3'(2 + RETRY_LEVELS - 1);

    // Largest wake delay
    localparam logic [MS_W-1:0] MS_MAX = '1;

    // Remainder width: any (diff - 1) at or above 1000 * (2^32 - 1) saturates,
    // and that bound fits in 42 bits.
    localparam int REM_W = 42;
    localparam logic [REM_W-1:0] SAT_LIMIT = 42'd4294967295000;

    // floor(y / 125) = (y * DIV_RECIP) >> DIV_SHIFT, exact for y < 2^39
    localparam int Y_W       = REM_W - 3;
    localparam int DIV_SHIFT = 46;
    localparam int RECIP_W   = 40;
    localparam int HALF_W    = 20;
    localparam logic [RECIP_W-1:0] DIV_RECIP = 40'd562949953422;

    // Beat handed from the deadline stages to the wake delay divider
    typedef struct packed {
        logic [TIME_W-1:0] due;
        logic [TIME_W-1:0] now;
        logic [MS_W-1:0]   retry;
        logic              batt_due;
    } t_wake_req;

endpackage

@@ rtl/rws_in_if.sv @@
// Command channel: valid/ready handshake with the command beat payload.
interface rws_in_if;
    logic                        valid;
    logic                        ready;
    logic [rws_pkg::CMD_W-1:0]   command;
    logic [rws_pkg::TIME_W-1:0]  now_time_us;
    logic                        batt_tried;

    modport source (output valid, command, now_time_us, batt_tried, input ready);
    modport sink   (input valid, command, now_time_us, batt_tried, output ready);
endinterface

@@ rtl/rws_out_if.sv @@
// Result channel: valid/ready handshake with the result beat payload.
interface rws_out_if;
    logic                      valid;
    logic                      ready;
    logic [rws_pkg::MS_W-1:0]  retry_delay_ms;
    logic [rws_pkg::MS_W-1:0]  wake_delay_ms;
    logic                      battery_is_due;

    modport source (output valid, retry_delay_ms, wake_delay_ms, battery_is_due, input ready);
    modport sink   (input valid, retry_delay_ms, wake_delay_ms, battery_is_due, output ready);
endinterface

@@ rtl/rws_wake_div.sv @@
// Wake delay pipeline: ceil((due - now) / 1000) with saturation, four stages.
module rws_wake_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    output logic                o_req_ready,
    input  rws_pkg::t_wake_req  i_req,
    rws_out_if.source           o_out
);

    localparam logic [rws_pkg::HALF_W-1:0] RECIP_HI =
        rws_pkg::DIV_RECIP[rws_pkg::RECIP_W-1:rws_pkg::HALF_W];
    localparam logic [rws_pkg::HALF_W-1:0] RECIP_LO =
        rws_pkg::DIV_RECIP[rws_pkg::HALF_W-1:0];
    localparam int YH_W   = rws_pkg::Y_W - rws_pkg::HALF_W;
    localparam int PHH_W  = YH_W + rws_pkg::HALF_W;
    localparam int PLL_W  = 2 * rws_pkg::HALF_W;
    localparam int MID_W  = PLL_W + 1;
    localparam int PROD_W = rws_pkg::Y_W + rws_pkg::RECIP_W;

    // Stage valids and advance terms
    logic r3_vld, r4_vld, r5_vld, r6_vld;
    logic adv3, adv4, adv5, adv6;

    assign adv6        = !r6_vld || o_out.ready;
    assign adv5        = !r5_vld || adv6;
    assign adv4        = !r4_vld || adv5;
    assign adv3        = !r3_vld || adv4;
    assign o_req_ready = adv3;

    // Stage 3: m = due - now - 1, positive-difference flag, high-bit check
    logic [rws_pkg::TIME_W-1:0] n3_m;
    logic [rws_pkg::REM_W-1:0]  r3_m;
    logic                       r3_hi_nz, r3_pos, r3_batt_due;
    logic [rws_pkg::MS_W-1:0]   r3_retry;

    assign n3_m = i_req.due + ~i_req.now;

    // Stage 4: saturation and partial products of y * recip
    logic [rws_pkg::Y_W-1:0]    y3;
    logic [YH_W-1:0]            y3_hi;
    logic [rws_pkg::HALF_W-1:0] y3_lo;
    logic [PHH_W-1:0]           r4_hh, r4_hl;
    logic [PLL_W-1:0]           r4_lh, r4_ll;
    logic                       r4_sat, r4_pos, r4_batt_due;
    logic [rws_pkg::MS_W-1:0]   r4_retry;

    assign y3    = r3_m[rws_pkg::REM_W-1:3];
    assign y3_hi = y3[rws_pkg::Y_W-1:rws_pkg::HALF_W];
    assign y3_lo = y3[rws_pkg::HALF_W-1:0];

    // Stage 5: cross terms summed
    logic [MID_W-1:0]           r5_mid;
    logic [PHH_W-1:0]           r5_hh;
    logic [PLL_W-1:0]           r5_ll;
    logic                       r5_sat, r5_pos, r5_batt_due;
    logic [rws_pkg::MS_W-1:0]   r5_retry;

    // Stage 6: full product, quotient and final wake delay
    logic [PROD_W-1:0]          prod5;
    logic [rws_pkg::MS_W-1:0]   quot5;
    logic [rws_pkg::MS_W-1:0]   n6_wake;
    logic [rws_pkg::MS_W-1:0]   r6_wake, r6_retry;
    logic                       r6_batt_due;

    assign prod5 = {r5_hh, {(2 * rws_pkg::HALF_W){1'b0}}}
                 + {{(PROD_W - MID_W - rws_pkg::HALF_W){1'b0}}, r5_mid,
                    {rws_pkg::HALF_W{1'b0}}}
                 + {{(PROD_W - PLL_W){1'b0}}, r5_ll};
    assign quot5 = prod5[rws_pkg::DIV_SHIFT + rws_pkg::MS_W - 1:rws_pkg::DIV_SHIFT];

    always_comb begin
        if (!r5_pos) begin
            n6_wake = '0;
        end else if (r5_sat) begin
            n6_wake = rws_pkg::MS_MAX;
        end else begin
            n6_wake = quot5 + rws_pkg::MS_W'(1);
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
        end else begin
            if (adv3) r3_vld <= i_req_valid;
            if (adv4) r4_vld <= r3_vld;
            if (adv5) r5_vld <= r4_vld;
            if (adv6) r6_vld <= r5_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (adv3 && i_req_valid) begin
            r3_m        <= n3_m[rws_pkg::REM_W-1:0];
            r3_hi_nz    <= |n3_m[rws_pkg::TIME_W-1:rws_pkg::REM_W];
            r3_pos      <= i_req.due > i_req.now;
            r3_retry    <= i_req.retry;
            r3_batt_due <= i_req.batt_due;
        end
        if (adv4 && r3_vld) begin
            r4_hh       <= y3_hi * RECIP_HI;
            r4_hl       <= y3_hi * RECIP_LO;
            r4_lh       <= y3_lo * RECIP_HI;
            r4_ll       <= y3_lo * RECIP_LO;
            r4_sat      <= r3_hi_nz || (r3_m >= rws_pkg::SAT_LIMIT);
            r4_pos      <= r3_pos;
            r4_retry    <= r3_retry;
            r4_batt_due <= r3_batt_due;
        end
        if (adv5 && r4_vld) begin
            r5_mid      <= {{(MID_W - PHH_W){1'b0}}, r4_hl} + {1'b0, r4_lh};
            r5_hh       <= r4_hh;
            r5_ll       <= r4_ll;
            r5_sat      <= r4_sat;
            r5_pos      <= r4_pos;
            r5_retry    <= r4_retry;
            r5_batt_due <= r4_batt_due;
        end
        if (adv6 && r5_vld) begin
            r6_wake     <= n6_wake;
            r6_retry    <= r5_retry;
            r6_batt_due <= r5_batt_due;
        end
    end

    assign o_out.valid          = r6_vld;
    assign o_out.retry_delay_ms = r6_retry;
    assign o_out.wake_delay_ms  = r6_wake;
    assign o_out.battery_is_due = r6_batt_due;

endmodule

@@ rtl/report_wake_scheduler_core.sv @@
// Report wake scheduler: deadline state, retry table and wake delay pipeline.
//
// Use: a command beat (clear, report succeeded, report failed, query) with
// the current time in microseconds enters on i_in; every command gives one
// result beat on o_out with the retry delay (failure only), the wake delay
// in ms until the earliest set deadline, and the battery-due flag.
// Intervals and the retry table are written through i_cfg_we / i_cfg_idx /
// i_cfg_data; the user must write them only while no command is in flight,
// which the block itself does not enforce. A command beat passes through the
// input register, deadline update, earliest-deadline select, then four
// stages that compute the rounded-up divide by 1000 with saturation.
// Throughput: one command per cycle while the receiver takes results; the
// deadline and retry-level update is a single register stage, so each
// command sees the state left by the one before it.
// Reset clears the deadlines, the retry level, all configuration registers
// and every stage valid bit. When the receiver stalls, results hold in the
// output register and bubbles further back are squeezed out; i_in.ready
// drops only once all seven stages hold a beat.
module report_wake_scheduler_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rws_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rws_pkg::CFG_W-1:0]         i_cfg_data,
    rws_in_if.sink                            i_in,
    rws_out_if.source                         o_out
);

    // Configuration registers
    logic [rws_pkg::MS_W-1:0] r_meter_iv, r_batt_iv;
    logic [rws_pkg::MS_W-1:0] r_retry_dly [rws_pkg::RETRY_LEVELS];
    logic [rws_pkg::LVL_W-1:0] cfg_rel;

    assign cfg_rel = rws_pkg::LVL_W'(i_cfg_idx - rws_pkg::REG_RETRY_0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meter_iv <= '0;
            r_batt_iv  <= '0;
            for (int i = 0; i < rws_pkg::RETRY_LEVELS; i++) begin
                r_retry_dly[i] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rws_pkg::REG_METER_IV: r_meter_iv <= i_cfg_data;
                rws_pkg::REG_BATT_IV:  r_batt_iv  <= i_cfg_data;
                default: begin
                    if (i_cfg_idx inside {[rws_pkg::REG_RETRY_0:rws_pkg::REG_RETRY_LAST]}) begin
                        r_retry_dly[cfg_rel] <= i_cfg_data;
                    end
                end
            endcase
        end
    end

    // Stage handshake
    logic r0_vld, r1_vld, r2_vld;
    logic adv1, adv2, req_ready;

    assign adv2       = !r2_vld || req_ready;
    assign adv1       = !r1_vld || adv2;
    assign i_in.ready = !r0_vld || adv1;

    // Stage 0: input register
    logic [rws_pkg::CMD_W-1:0]  r0_cmd;
    logic [rws_pkg::TIME_W-1:0] r0_now;
    logic                       r0_batt;

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r0_cmd  <= i_in.command;
            r0_now  <= i_in.now_time_us;
            r0_batt <= i_in.batt_tried;
        end
    end

    // Stage 1: deadline and retry-level update
    logic [rws_pkg::TIME_W-1:0] r_meter_dl, r_batt_dl, n_meter_dl, n_batt_dl;
    logic [rws_pkg::LVL_W-1:0]  r_lvl, n_lvl, lvl_idx;
    logic [rws_pkg::MS_W-1:0]   n1_retry, r1_retry;
    logic [rws_pkg::TIME_W-1:0] r1_now;
    logic [rws_pkg::TIME_W-1:0] meter_ext, batt_ext, meter_us, batt_us;

    // interval * 1000 as (x << 10) - (x << 4) - (x << 3)
    assign meter_ext = {{(rws_pkg::TIME_W - rws_pkg::MS_W){1'b0}}, r_meter_iv};
    assign batt_ext  = {{(rws_pkg::TIME_W - rws_pkg::MS_W){1'b0}}, r_batt_iv};
    assign meter_us  = (meter_ext << 10) - (meter_ext << 4) - (meter_ext << 3);
    assign batt_us   = (batt_ext << 10) - (batt_ext << 4) - (batt_ext << 3);

    // Table index clamped to the last level
    assign lvl_idx = (r_lvl >= rws_pkg::LVL_W'(rws_pkg::RETRY_LEVELS - 1))
                   ? rws_pkg::LVL_W'(rws_pkg::RETRY_LEVELS - 1) : r_lvl;

    always_comb begin
        n_meter_dl = r_meter_dl;
        n_batt_dl  = r_batt_dl;
        n_lvl      = r_lvl;
        n1_retry   = '0;
        case (r0_cmd)
            rws_pkg::CMD_CLEAR: begin
                n_meter_dl = '0;
                n_batt_dl  = '0;
                n_lvl      = '0;
            end
            rws_pkg::CMD_SUCCESS: begin
                n_meter_dl = r0_now + meter_us;
                if (r0_batt) begin
                    n_batt_dl = r0_now + batt_us;
                end
                n_lvl = '0;
            end
            rws_pkg::CMD_FAIL: begin
                n1_retry = r_retry_dly[lvl_idx];
                if (r_lvl < rws_pkg::LVL_W'(rws_pkg::RETRY_LEVELS - 1)) begin
                    n_lvl = r_lvl + rws_pkg::LVL_W'(1);
                end
            end
            rws_pkg::CMD_QUERY: begin
                n1_retry = '0;
            end
            default: begin
                n1_retry = '0;
            end
        endcase
    end

    // Stage 2: earliest set deadline and battery-due flag
    logic [rws_pkg::TIME_W-1:0] n2_due, r2_due, r2_now;
    logic [rws_pkg::MS_W-1:0]   r2_retry;
    logic                       r2_batt_due;

    always_comb begin
        n2_due = r_meter_dl;
        if (r_meter_dl == '0 || (r_batt_dl != '0 && r_batt_dl < r_meter_dl)) begin
            n2_due = r_batt_dl;
        end
    end

    // Control state and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld     <= 1'b0;
            r1_vld     <= 1'b0;
            r2_vld     <= 1'b0;
            r_meter_dl <= '0;
            r_batt_dl  <= '0;
            r_lvl      <= '0;
        end else begin
            if (i_in.ready) r0_vld <= i_in.valid;
            if (adv1)       r1_vld <= r0_vld;
            if (adv2)       r2_vld <= r1_vld;
            if (adv1 && r0_vld) begin
                r_meter_dl <= n_meter_dl;
                r_batt_dl  <= n_batt_dl;
                r_lvl      <= n_lvl;
            end
        end
    end

    // Stage 1 and 2 payload
    always_ff @(posedge i_clk) begin
        if (adv1 && r0_vld) begin
            r1_now   <= r0_now;
            r1_retry <= n1_retry;
        end
        if (adv2 && r1_vld) begin
            r2_due      <= n2_due;
            r2_now      <= r1_now;
            r2_retry    <= r1_retry;
            r2_batt_due <= (r_batt_dl == '0) || (r1_now >= r_batt_dl);
        end
    end

    // Wake delay divider and output register
    rws_pkg::t_wake_req req;

    assign req.due      = r2_due;
    assign req.now      = r2_now;
    assign req.retry    = r2_retry;
    assign req.batt_due = r2_batt_due;

    rws_wake_div u_wake_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (r2_vld),
        .o_req_ready (req_ready),
        .i_req       (req),
        .o_out       (o_out)
    );

endmodule

@@ verif/tb_report_wake_scheduler_core.sv @@
// Self-checking testbench for the report wake scheduler core: command driver, result monitor.
`timescale 1ns / 1ps

module tb_report_wake_scheduler_core;

    // Spare register indexes: writes there must not touch anything
    localparam logic [rws_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [rws_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    localparam logic [rws_pkg::TIME_W-1:0] TIME_MAX = '1;

    // Receiver hold-off that backs the pipeline up into the command port
    localparam int HOLD_AT_BEAT = 150;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_REPORTS  = 40;

    typedef struct packed {
        logic [rws_pkg::CMD_W-1:0]  op;
        logic [rws_pkg::TIME_W-1:0] now_us;
        logic                       batt_tried;
    } t_sched_cmd;

    typedef struct packed {
        logic [rws_pkg::MS_W-1:0] retry_delay_ms;
        logic [rws_pkg::MS_W-1:0] wake_delay_ms;
        logic                     battery_is_due;
    } t_wake_result;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [rws_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [rws_pkg::CFG_W-1:0]     i_cfg_data;

    rws_in_if  cmd_bus ();
    rws_out_if res_bus ();

    report_wake_scheduler_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (cmd_bus),
        .o_out      (res_bus)
    );

    always #6 i_clk = ~i_clk;

    // Scheduler mirror: settings and deadline state
    logic [rws_pkg::MS_W-1:0]   meter_iv_ms;
    logic [rws_pkg::MS_W-1:0]   batt_iv_ms;
    logic [rws_pkg::MS_W-1:0]   retry_tbl [rws_pkg::RETRY_LEVELS];
    logic [rws_pkg::TIME_W-1:0] meter_dl_us;
    logic [rws_pkg::TIME_W-1:0] batt_due_us;
    logic [rws_pkg::LVL_W-1:0]  retry_lvl;

    t_sched_cmd   pending_cmds[$];
    t_wake_result expected_wakes[$];

    int  err_cnt    = 0;
    int  tx_gap     = 0;
    int  rx_stall   = 0;
    int  rx_beats   = 0;
    bit  hold_done  = 1'b0;
    bit  tx_idle_on = 1'b1;
    bit  rx_idle_on = 1'b1;

    // Apply one command to the mirror and return the result it must produce
    function automatic t_wake_result schedule_step(
        input logic [rws_pkg::CMD_W-1:0]  op,
        input logic [rws_pkg::TIME_W-1:0] now_us,
        input logic                       batt_tried);
        t_wake_result               res;
        logic [rws_pkg::TIME_W-1:0] due_us;
        logic [rws_pkg::TIME_W-1:0] diff_us;
        logic [rws_pkg::TIME_W-1:0] ceil_ms;
        res.retry_delay_ms = '0;
        case (op)
            rws_pkg::CMD_CLEAR: begin
                meter_dl_us = '0;
                batt_due_us = '0;
                retry_lvl   = '0;
            end
            rws_pkg::CMD_SUCCESS: begin
                meter_dl_us = now_us + 64'(meter_iv_ms) * 64'd1000;
                if (batt_tried)
                    batt_due_us = now_us + 64'(batt_iv_ms) * 64'd1000;
                retry_lvl = '0;
            end
            rws_pkg::CMD_FAIL: begin
                res.retry_delay_ms = retry_tbl[retry_lvl];
                if (retry_lvl < rws_pkg::RETRY_LEVELS - 1)
                    retry_lvl = retry_lvl + 1'b1;
            end
            rws_pkg::CMD_QUERY: ;
            default: ;
        endcase
        res.battery_is_due = (batt_due_us == '0) || (now_us >= batt_due_us);
        // earliest set deadline; zero means unset
        due_us = meter_dl_us;
        if (due_us == '0 || (batt_due_us != '0 && batt_due_us < due_us))
            due_us = batt_due_us;
        if (due_us <= now_us) begin
            res.wake_delay_ms = '0;
        end else begin
            diff_us = due_us - now_us;
            ceil_ms = diff_us / 64'd1000 + 64'((diff_us % 64'd1000) != '0);
            res.wake_delay_ms = (ceil_ms > 64'(rws_pkg::MS_MAX)) ? rws_pkg::MS_MAX
                                                                 : ceil_ms[rws_pkg::MS_W-1:0];
        end
        return res;
    endfunction

    // Mostly no gap, some short, a few long
    function automatic int pick_gap(input bit idle_on);
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void queue_cmd(input logic [rws_pkg::CMD_W-1:0]  op,
                                      input logic [rws_pkg::TIME_W-1:0] now_us,
                                      input logic                       batt_tried);
        t_sched_cmd c;
        c.op         = op;
        c.now_us     = now_us;
        c.batt_tried = batt_tried;
        pending_cmds.push_back(c);
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
            $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
    endtask

    // Register write; call right after a rising edge, returns at the next one
    task automatic write_reg(input logic [rws_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rws_pkg::CFG_W-1:0]     val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            rws_pkg::REG_METER_IV: meter_iv_ms = val;
            rws_pkg::REG_BATT_IV:  batt_iv_ms  = val;
            default: begin
                if (idx >= rws_pkg::REG_RETRY_0 && idx <= rws_pkg::REG_RETRY_LAST)
                    retry_tbl[rws_pkg::LVL_W'(idx - rws_pkg::REG_RETRY_0)] = val;
            end
        endcase
        @(posedge i_clk);
    endtask

    // Wait until every queued command has come back, then let the pipe settle
    task automatic drain();
        do
            @(negedge i_clk);
        while (pending_cmds.size() != 0 || cmd_bus.valid || expected_wakes.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // New random settings, then a run of commands around the deadlines
    task automatic run_random_phase(input int n_cmds, input bit idle_on);
        logic [rws_pkg::TIME_W-1:0] clk_us;
        logic [rws_pkg::TIME_W-1:0] base_us;
        logic [rws_pkg::CFG_W-1:0]  val;
        logic [rws_pkg::CMD_W-1:0]  op;
        int                         pick;
        for (int idx = rws_pkg::REG_METER_IV; idx <= rws_pkg::REG_RETRY_LAST; idx++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                val = '0;
            else if (pick == 1)
                val = rws_pkg::MS_MAX;
            else if (pick < 7)
                val = $urandom_range(1, 40);
            else
                val = $urandom;
            write_reg(rws_pkg::CFG_IDX_W'(idx), val);
        end
        write_reg(REG_SPARE_6, $urandom);
        write_reg(REG_SPARE_7, $urandom);
        i_cfg_we   <= 1'b0;
        tx_idle_on = idle_on;
        rx_idle_on = idle_on;

        // start near zero, anywhere, or just below the wrap point
        pick = $urandom_range(0, 2);
        if (pick == 0)
            clk_us = '0;
        else if (pick == 1)
            clk_us = {$urandom, $urandom};
        else
            clk_us = TIME_MAX - 64'($urandom_range(0, 100000));
        base_us = clk_us;

        repeat (n_cmds) begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                op = rws_pkg::CMD_CLEAR;
            else if (pick < 35)
                op = rws_pkg::CMD_SUCCESS;
            else if (pick < 65)
                op = rws_pkg::CMD_FAIL;
            else
                op = rws_pkg::CMD_QUERY;
            pick = $urandom_range(0, 99);
            if (pick < 65)
                clk_us = clk_us + 64'($urandom_range(0, 20000));
            else if (pick < 85)
                // within a millisecond of the meter or battery deadline
                clk_us = base_us + 64'(pick[0] ? meter_iv_ms : batt_iv_ms) * 64'd1000
                         + 64'($urandom_range(0, 2000)) - 64'd1000;
            else if (pick < 95)
                clk_us = {$urandom, $urandom};
            // otherwise time stands still
            if (op == rws_pkg::CMD_SUCCESS)
                base_us = clk_us;
            queue_cmd(op, clk_us, 1'($urandom_range(0, 1)));
        end
        drain();
    endtask

    // Command driver
    always @(posedge i_clk) begin
        t_sched_cmd beat;
        if (!i_rst_n) begin
            cmd_bus.valid <= 1'b0;
            tx_gap        <= 0;
        end else begin
            if (cmd_bus.valid && cmd_bus.ready)
                expected_wakes.push_back(schedule_step(cmd_bus.command, cmd_bus.now_time_us,
                                                       cmd_bus.batt_tried));
            if (!cmd_bus.valid || cmd_bus.ready) begin
                if (tx_gap != 0) begin
                    tx_gap        <= tx_gap - 1;
                    cmd_bus.valid <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    beat = pending_cmds.pop_front();
                    cmd_bus.valid       <= 1'b1;
                    cmd_bus.command     <= beat.op;
                    cmd_bus.now_time_us <= beat.now_us;
                    cmd_bus.batt_tried  <= beat.batt_tried;
                    tx_gap              <= pick_gap(tx_idle_on);
                end else begin
                    cmd_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver back-pressure
    always @(posedge i_clk) begin
        t_wake_result want;
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
            rx_stall      <= 0;
        end else begin
            if (res_bus.valid && res_bus.ready) begin
                rx_beats++;
                if (expected_wakes.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("%0t ns: result beat with no command outstanding, wake %0d",
                                 $time, res_bus.wake_delay_ms);
                end else begin
                    want = expected_wakes.pop_front();
                    if (res_bus.retry_delay_ms !== want.retry_delay_ms)
                        flag_mismatch("retry_delay_ms", 64'(want.retry_delay_ms),
                                      64'(res_bus.retry_delay_ms));
                    if (res_bus.wake_delay_ms !== want.wake_delay_ms)
                        flag_mismatch("wake_delay_ms", 64'(want.wake_delay_ms),
                                      64'(res_bus.wake_delay_ms));
                    if (res_bus.battery_is_due !== want.battery_is_due)
                        flag_mismatch("battery_is_due", 64'(want.battery_is_due),
                                      64'(res_bus.battery_is_due));
                end
            end
            if (rx_beats >= HOLD_AT_BEAT && !hold_done) begin
                hold_done = 1'b1;
                res_bus.ready <= 1'b0;
                rx_stall      <= HOLD_CYCLES;
            end else if (rx_stall != 0) begin
                res_bus.ready <= 1'b0;
                rx_stall      <= rx_stall - 1;
            end else begin
                res_bus.ready <= 1'b1;
                rx_stall      <= pick_gap(rx_idle_on);
            end
        end
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Stimulus sequence
    initial begin
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        meter_iv_ms = '0;
        batt_iv_ms  = '0;
        for (int i = 0; i < rws_pkg::RETRY_LEVELS; i++)
            retry_tbl[i] = '0;
        meter_dl_us = '0;
        batt_due_us = '0;
        retry_lvl   = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: nothing set, then deadlines at the very top of time
        queue_cmd(rws_pkg::CMD_QUERY, '0, 1'b0);
        queue_cmd(rws_pkg::CMD_SUCCESS, TIME_MAX, 1'b1);
        queue_cmd(rws_pkg::CMD_QUERY, '0, 1'b1);                  // difference near 2^64 saturates
        queue_cmd(rws_pkg::CMD_QUERY, TIME_MAX - 64'd1, 1'b0);
        queue_cmd(rws_pkg::CMD_QUERY, TIME_MAX - 64'd1001, 1'b0); // rounds up to 2 ms
        queue_cmd(rws_pkg::CMD_FAIL, '0, 1'b1);
        drain();

        // Small intervals: retry ladder and its clamp, deadline boundaries
        write_reg(rws_pkg::REG_METER_IV, 32'd1);
        write_reg(rws_pkg::REG_BATT_IV, 32'd2);
        for (int i = 0; i < rws_pkg::RETRY_LEVELS; i++)
            write_reg(rws_pkg::CFG_IDX_W'(rws_pkg::REG_RETRY_0 + i), 32'(10 * (i + 1)));
        i_cfg_we <= 1'b0;
        queue_cmd(rws_pkg::CMD_CLEAR, TIME_MAX, 1'b1);
        repeat (5) queue_cmd(rws_pkg::CMD_FAIL, 64'd7, 1'b0);
        queue_cmd(rws_pkg::CMD_SUCCESS, 64'd1000, 1'b1);
        queue_cmd(rws_pkg::CMD_FAIL, 64'd1000, 1'b0);
        queue_cmd(rws_pkg::CMD_QUERY, 64'd1999, 1'b0);
        queue_cmd(rws_pkg::CMD_QUERY, 64'd2000, 1'b0);            // meter deadline reached
        queue_cmd(rws_pkg::CMD_QUERY, 64'd3000, 1'b0);            // battery just due
        queue_cmd(rws_pkg::CMD_SUCCESS, 64'd5000, 1'b0);          // stale battery deadline is earliest
        queue_cmd(rws_pkg::CMD_CLEAR, 64'd5000, 1'b0);
        queue_cmd(rws_pkg::CMD_SUCCESS, '0, 1'b0);                // battery stays unset
        drain();

        // Largest intervals: saturation edge and sums wrapping past 2^64
        write_reg(rws_pkg::REG_METER_IV, rws_pkg::MS_MAX);
        write_reg(rws_pkg::REG_BATT_IV, rws_pkg::MS_MAX);
        i_cfg_we <= 1'b0;
        queue_cmd(rws_pkg::CMD_SUCCESS, '0, 1'b1);
        queue_cmd(rws_pkg::CMD_SUCCESS, 64'd0 - 64'd4294967295000, 1'b1);  // both wrap to unset
        queue_cmd(rws_pkg::CMD_SUCCESS, TIME_MAX, 1'b1);
        queue_cmd(rws_pkg::CMD_QUERY, '0, 1'b0);
        queue_cmd(rws_pkg::CMD_QUERY, 64'd1000, 1'b0);
        drain();

        // Random settings and traffic; one stretch runs without idling
        for (int ph = 0; ph < 5; ph++)
            run_random_phase(96, ph != 3);

        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/rws_pkg.sv
rtl/rws_in_if.sv
rtl/rws_out_if.sv
rtl/rws_wake_div.sv
rtl/report_wake_scheduler_core.sv
verif/tb_report_wake_scheduler_core.sv
